[rtl/edge_period_frequency_meter_core_assert.svh]
// ============================================================================
// Assertion macros for the edge period frequency meter
// Shared clocked property forms used by the checker.
// ============================================================================
`ifndef EDGE_PERIOD_FREQUENCY_METER_CORE_ASSERT_SVH
`define EDGE_PERIOD_FREQUENCY_METER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EPFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EPFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/epfm_pkg.sv]
// ============================================================================
// Edge period frequency meter package
// Field widths, register indexes, reset values and shared types.
// ============================================================================
package epfm_pkg;

   // Field widths
   localparam int CLK_W       = 29;
   localparam int PRE_W       = 16;
   localparam int CV_W        = 16;
   localparam int FREQ_W      = 29;
   localparam int HALF_W      = 28;
   localparam int DIVISOR_W   = PRE_W + 1 + CLK_W;

   // Channel widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 29;

   // Default parameter values
   localparam int COUNTER_BITS_DEF  = 16;
   localparam int OVERFLOW_BITS_DEF = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESCALE = 1'b1;

   // Register reset values
   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 29'd180000000;
   localparam logic [PRE_W-1:0] PRESCALE_RESET = 16'd1799;

   // Item kinds on req_tuser
   localparam logic REQ_OVERFLOW = 1'b0;
   localparam logic REQ_EDGE     = 1'b1;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [CLK_W-1:0] clock_hz;
      logic [PRE_W-1:0] prescale;
   } cfg_type;

endpackage

[rtl/epfm_alu.sv]
// ============================================================================
// Shared subtract and compare unit
// Gives a - b and a borrow flag that is set when b exceeds a.
// ============================================================================
module epfm_alu
   import epfm_pkg::*;
#(
   parameter int WIDTH = DIVISOR_W + 1
) (
   input  logic [WIDTH-1:0] alu_a,
   input  logic [WIDTH-1:0] alu_b,
   output logic [WIDTH-1:0] alu_diff,
   output logic             alu_borrow
);

   // Subtract with one extra bit to catch the borrow
   assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};

endmodule

[rtl/epfm_csr.sv]
// ============================================================================
// Configuration registers
// Holds the clock frequency and timer prescaler written over the csr port.
// ============================================================================
module epfm_csr
   import epfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CLOCK_HZ: cfg_in.clock_hz = csr_wdata[CLK_W-1:0];
            CSR_PRESCALE: cfg_in.prescale = csr_wdata[PRE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_hz <= CLOCK_HZ_RESET;
         cfg_ff.prescale <= PRESCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/edge_period_frequency_meter_core.sv]
// ============================================================================
// Edge period frequency meter
// Reciprocal frequency counter: elapsed timer ticks between sensor edges,
// scaled by the prescaler, divide the core clock to give the edge frequency.
// ============================================================================
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_tvalid/req_tready | tuser kind, tdata timer value
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata frequency, half freq
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// An overflow item is taken while the sequencer is idle and gives no result.
// An edge item holds the block through S_ELAPSED, S_RANGE, S_MUL, the 29
// steps of restoring division on the shared subtractor in S_DIV, and S_DONE
// that loads its result (S_RANGE goes straight to S_DONE when the elapsed
// time is zero, backwards or above clock_hz ticks). Reset returns registers
// to their defaults and clears the count state. A result held in the output
// stalls only the next edge item, in S_DONE; idle overflows are still taken.
//
module edge_period_frequency_meter_core
   import epfm_pkg::*;
#(
   parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
   parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [15:0] counter_value
   input  logic                   req_tuser,  // [0] req_type
   // Result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [28:0] frequency,
                                              // [56:29] half_frequency
   // Configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SPAN_W = COUNTER_BITS + OVERFLOW_BITS;
   localparam int ALU_W  = (SPAN_W > DIVISOR_W + 1) ? SPAN_W : DIVISOR_W + 1;
   localparam int STEP_W = $clog2(CLK_W);
   localparam int PAD_W  = RSP_TDATA_W - FREQ_W - HALF_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ELAPSED = 3'd1;
   localparam logic [2:0] S_RANGE   = 3'd2;
   localparam logic [2:0] S_MUL     = 3'd3;
   localparam logic [2:0] S_DIV     = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   cfg_type                cfg;

   logic [2:0]             state_ff,      state_in;
   logic [SPAN_W-1:0]      span_ff,       span_in;
   logic [COUNTER_BITS-1:0]  prev_ff,     prev_in;
   logic [OVERFLOW_BITS-1:0] ovf_ff,      ovf_in;
   logic [SPAN_W-1:0]      elapsed_ff,    elapsed_in;
   logic [DIVISOR_W-1:0]   divisor_ff,    divisor_in;
   logic [DIVISOR_W-1:0]   rem_ff,        rem_in;
   logic [CLK_W-1:0]       quot_ff,       quot_in;
   logic [STEP_W-1:0]      step_ff,       step_in;
   logic [FREQ_W-1:0]      last_freq_ff,  last_freq_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   logic [FREQ_W-1:0]      rsp_freq_ff,   rsp_freq_in;

   logic [ALU_W-1:0]       alu_a;
   logic [ALU_W-1:0]       alu_b;
   logic [ALU_W-1:0]       alu_diff;
   logic                   alu_borrow;

   logic [COUNTER_BITS-1:0] now;
   logic [DIVISOR_W:0]      rem_shift;
   logic [PRE_W:0]          ticks_per_count;
   logic [DIVISOR_W-1:0]    product;

   epfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   epfm_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_diff   (alu_diff),
      .alu_borrow (alu_borrow)
   );

   // Captured timer value at this counter width
   assign now = COUNTER_BITS'(req_tdata[CV_W-1:0]);

   // Next partial remainder of the division
   assign rem_shift = {rem_ff, quot_ff[CLK_W-1]};

   // Clocks per elapsed count times elapsed counts
   assign ticks_per_count = {1'b0, cfg.prescale} + 1'b1;
   assign product = DIVISOR_W'(ticks_per_count) * DIVISOR_W'(CLK_W'(elapsed_ff));

   // Steer the shared subtractor
   always_comb begin
      unique case (state_ff)
         S_ELAPSED: begin
            alu_a = ALU_W'(span_ff);
            alu_b = ALU_W'(prev_ff);
         end
         S_RANGE: begin
            alu_a = ALU_W'(cfg.clock_hz);
            alu_b = ALU_W'(elapsed_ff);
         end
         S_DIV: begin
            alu_a = ALU_W'(rem_shift);
            alu_b = ALU_W'(divisor_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // Sequencer and datapath updates
   always_comb begin
      state_in     = state_ff;
      span_in      = span_ff;
      prev_in      = prev_ff;
      ovf_in       = ovf_ff;
      elapsed_in   = elapsed_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      last_freq_in = last_freq_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_freq_in  = rsp_freq_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_EDGE) begin
                  span_in  = {ovf_ff, now};
                  state_in = S_ELAPSED;
               end else if (ovf_ff != '1) begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end
         end
         S_ELAPSED: begin
            // Backwards edge counts as no elapsed time
            elapsed_in = alu_borrow ? '0 : alu_diff[SPAN_W-1:0];
            prev_in    = span_ff[COUNTER_BITS-1:0];
            ovf_in     = '0;
            state_in   = S_RANGE;
         end
         S_RANGE: begin
            priority if (elapsed_ff == '0) begin
               state_in = S_DONE;
            end else if (alu_borrow) begin
               // More elapsed ticks than clock_hz
               last_freq_in = '0;
               state_in     = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            divisor_in = product;
            rem_in     = '0;
            quot_in    = cfg.clock_hz;
            step_in    = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            // Restoring division, one quotient bit a cycle
            rem_in  = alu_borrow ? rem_shift[DIVISOR_W-1:0] : alu_diff[DIVISOR_W-1:0];
            quot_in = {quot_ff[CLK_W-2:0], ~alu_borrow};
            if (step_ff == STEP_W'(CLK_W - 1)) begin
               last_freq_in = quot_in;
               state_in     = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = last_freq_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         ovf_ff       <= '0;
         last_freq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         ovf_ff       <= ovf_in;
         last_freq_ff <= last_freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff     <= span_in;
      elapsed_ff  <= elapsed_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rsp_freq_ff <= rsp_freq_in;
   end

   // Drive the channels
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_freq_ff[FREQ_W-1:1], rsp_freq_ff};

endmodule

[rtl/epfm_checker.sv]
// ============================================================================
// Edge period frequency meter checker
// Port-level properties of the meter, bound to the top level.
// ============================================================================
`include "edge_period_frequency_meter_core_assert.svh"

module epfm_checker
   import epfm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Hold a stalled result item
   `EPFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result item changed")

   // Half frequency tracks the frequency field
   `EPFM_ASSERT_NOW(a_rsp_half, clock, reset, rsp_tvalid, rsp_tdata[56:29] == rsp_tdata[28:1], "half frequency mismatch")

   // Keep the padding bits clear
   `EPFM_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[63:57] == 7'd0, "result padding not zero")

   // An overflow item gives no result
   `EPFM_ASSERT_NEXT(a_ovf_silent, clock, reset, req_tvalid && req_tready && (req_tuser == REQ_OVERFLOW) && !rsp_tvalid, !rsp_tvalid, "result after overflow item")

   // An edge item keeps the sequencer busy
   `EPFM_ASSERT_NEXT(a_edge_busy, clock, reset, req_tvalid && req_tready && (req_tuser == REQ_EDGE), !req_tready, "ready straight after edge item")

endmodule

bind edge_period_frequency_meter_core epfm_checker u_epfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/edge_period_frequency_meter_core_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// Edge period frequency meter checker
// Watches the request, result and register channels. It keeps its own copy
// of the timer state and the register values, predicts the reading for each
// accepted edge item and compares each result item with the oldest
// outstanding reading.
// ============================================================================
module edge_period_frequency_meter_core_checker
   import epfm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [15:0] counter_value
   input  logic                   req_tuser,  // [0] req_type
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // [28:0] frequency,
                                              // [56:29] half_frequency
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     pending,
   output int                     compared
);

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [HALF_W-1:0] half;
   } meter_reading_type;

   // Outstanding readings, oldest first
   meter_reading_type readings[$];

   // Shadow registers and timer state
   logic [CLK_W-1:0] clock_hz;
   logic [PRE_W-1:0] prescale;
   logic [15:0]      last_count;
   logic [15:0]      wraps;
   logic [31:0]      held_freq;

   int mismatch_total = 0;
   int checked = 0;

   // Count a mismatch; report only the first few in full
   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      logic [63:0]       span;
      logic [63:0]       elapsed;
      logic [15:0]       now;
      meter_reading_type got;
      meter_reading_type want;
      if (reset) begin
         clock_hz   = CLOCK_HZ_RESET;
         prescale   = PRESCALE_RESET;
         last_count = '0;
         wraps      = '0;
         held_freq  = '0;
         readings.delete();
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOCK_HZ: clock_hz = csr_wdata[CLK_W-1:0];
               CSR_PRESCALE: prescale = csr_wdata[PRE_W-1:0];
               default: ;
            endcase
         end

         // Compare a result item with the oldest outstanding reading
         if (rsp_tvalid && rsp_tready) begin
            got.freq = rsp_tdata[FREQ_W-1:0];
            got.half = rsp_tdata[FREQ_W+HALF_W-1:FREQ_W];
            if (readings.size() == 0) begin
               note_mismatch("result with none outstanding", '0, 32'(got.freq));
            end else begin
               want = readings.pop_front();
               checked++;
               if (got.freq !== want.freq)
                  note_mismatch("frequency", 32'(want.freq), 32'(got.freq));
               if (got.half !== want.half)
                  note_mismatch("half_frequency", 32'(want.half), 32'(got.half));
            end
         end

         // Advance the timer state for an accepted item
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_OVERFLOW) begin
               // saturate the overflow count
               if (wraps != 16'hFFFF)
                  wraps = wraps + 16'd1;
            end else begin
               now     = req_tdata[15:0];
               span    = 64'(now) + (64'(wraps) << COUNTER_BITS);
               elapsed = (span >= 64'(last_count)) ? span - 64'(last_count) : 64'd0;
               // hold the previous reading on zero or backward elapsed time
               if (elapsed != 0) begin
                  if (elapsed > 64'(clock_hz))
                     held_freq = '0;
                  else
                     held_freq = 32'(64'(clock_hz) / ((64'(prescale) + 64'd1) * elapsed));
               end
               last_count = now;
               wraps      = '0;
               want.freq  = held_freq[FREQ_W-1:0];
               want.half  = held_freq[HALF_W:1];
               readings.push_back(want);
            end
         end
      end
      failures <= mismatch_total;
      pending  <= readings.size();
      compared <= checked;
   end

endmodule

[dv/edge_period_frequency_meter_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Edge period frequency meter testbench
// Drives sensor edge and timer overflow items through several register
// settings, with a directed opening and random edge sequences; a checker
// beside the block predicts and compares readings.
// ============================================================================
module edge_period_frequency_meter_core_tb;
   import epfm_pkg::*;

   localparam int RUN_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 255;
   localparam int PHASES        = 6;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = REQ_OVERFLOW;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_CLOCK_HZ;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int failures;
   int pending;
   int compared;

   int          cycle_count    = 0;
   int          burst_left     = 0;
   bit          idling_on      = 1'b1;
   int          edges_sent     = 0;
   int          overflows_sent = 0;
   int          writes_done    = 0;
   logic [15:0] shadow_count   = '0;

   // Receiver stall state
   int          stall_left   = 0;
   logic [9:0]  stall_phase  = '0;

   edge_period_frequency_meter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   edge_period_frequency_meter_core_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending),
      .compared   (compared)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: free-flowing, random, long-stall and fixed-pattern stretches in turn
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left  <= stall_left - 1;
         rsp_tready  <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 10'd1;
         case (stall_phase[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left <= $urandom_range(1, 15);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
            default: rsp_tready <= stall_phase[0] ^ stall_phase[2];
         endcase
      end
   end

   // Send one item; open a new burst with a random gap where due
   task automatic send_item(input logic kind, input logic [15:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (idling_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_EDGE) begin
         edges_sent++;
         shadow_count = value;
      end else begin
         overflows_sent++;
      end
   endtask

   // Hold off until every reading has arrived and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      writes_done++;
      @(posedge clock);
   endtask

   // One random step: mostly a well-formed edge after its timer wraps,
   // otherwise stray overflows, random, repeated or backward edges
   task automatic random_step();
      int          pick;
      logic [31:0] delta;
      logic [31:0] total;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         case ($urandom_range(0, 3))
            0: delta = $urandom_range(1, 16);
            1: delta = $urandom_range(1, 1024);
            2: delta = $urandom_range(1, 70000);
            default: delta = $urandom_range(1, 300000);
         endcase
         total = 32'(shadow_count) + delta;
         for (int k = 0; k < int'(total >> 16); k++)
            send_item(REQ_OVERFLOW, 16'($urandom));
         send_item(REQ_EDGE, total[15:0]);
      end else if (pick < 78) begin
         send_item(REQ_OVERFLOW, 16'($urandom));
      end else if (pick < 86) begin
         send_item(REQ_EDGE, 16'($urandom));
      end else if (pick < 92) begin
         send_item(REQ_EDGE, shadow_count);
      end else if (shadow_count != 0) begin
         send_item(REQ_EDGE, shadow_count - 16'($urandom_range(1, shadow_count)));
      end else begin
         send_item(REQ_EDGE, 16'($urandom));
      end
   endtask

   initial begin
      logic [CLK_W-1:0] clock_set[PHASES];
      logic [PRE_W-1:0] prescale_set[PHASES];
      int               start_items;

      clock_set[0] = 29'd400000000;  prescale_set[0] = 16'd0;
      clock_set[1] = 29'd1;          prescale_set[1] = 16'd0;
      clock_set[2] = 29'd0;          prescale_set[2] = 16'hFFFF;
      clock_set[3] = 29'h1FFFFFFF;   prescale_set[3] = 16'hFFFF;
      clock_set[4] = 29'($urandom_range(1, 400000000));
      prescale_set[4] = 16'($urandom_range(0, 65535));
      clock_set[5] = CLOCK_HZ_RESET; prescale_set[5] = PRESCALE_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed opening at the reset register values
      send_item(REQ_EDGE, 16'h0000);      // zero elapsed right after reset
      send_item(REQ_EDGE, 16'h0001);      // one tick
      send_item(REQ_EDGE, 16'h0001);      // zero elapsed repeats the reading
      send_item(REQ_EDGE, 16'h0000);      // backward edge repeats the reading
      send_item(REQ_EDGE, 16'hFFFF);
      send_item(REQ_OVERFLOW, 16'hFFFF);
      send_item(REQ_EDGE, 16'hFFFF);      // exactly one wrap
      send_item(REQ_OVERFLOW, 16'h0000);
      send_item(REQ_OVERFLOW, 16'h5555);
      send_item(REQ_EDGE, 16'h0000);      // two wraps, 65537 ticks
      send_item(REQ_EDGE, 16'h5555);
      send_item(REQ_EDGE, 16'hAAAA);
      send_item(REQ_OVERFLOW, 16'hAAAA);
      send_item(REQ_EDGE, 16'h0001);
      send_item(REQ_EDGE, 16'h0003);      // two ticks
      send_item(REQ_EDGE, 16'h0004);
      send_item(REQ_EDGE, 16'h0009);
      send_item(REQ_EDGE, 16'h0009);

      // Random phases, each at its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_reg(CSR_CLOCK_HZ, CSR_DATA_W'(clock_set[phase]));
         write_reg(CSR_PRESCALE, CSR_DATA_W'(prescale_set[phase]));

         idling_on   = ($urandom_range(0, 4) != 0);
         start_items = edges_sent + overflows_sent;
         while (edges_sent + overflows_sent - start_items < PHASE_ITEMS) begin
            random_step();
            if ($urandom_range(0, 199) == 0)
               settle();
            if ($urandom_range(0, 99) == 0)
               idling_on = !idling_on;
         end
      end

      // Drain and decide
      settle();
      $display("Run: %0d edge and %0d overflow items over %0d register writes",
               edges_sent, overflows_sent, writes_done);
      $display("     %0d readings compared, %0d mismatches", compared, failures);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
